### rtl/hslrgb_pkg.sv
`default_nettype none

package hslrgb_pkg;

    typedef struct packed {
        logic [15:0] hue;
        logic [16:0] saturation;
        logic [16:0] lightness;
    } t_hsl_in;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [31:0] packed_argb;
    } t_rgb_out;

    typedef enum logic [2:0] {
        SEXT_RY = 3'd0,
        SEXT_YG = 3'd1,
        SEXT_GC = 3'd2,
        SEXT_CB = 3'd3,
        SEXT_BM = 3'd4,
        SEXT_MR = 3'd5
    } t_sextant;

    localparam logic [7:0] ALPHA    = 8'hFF;
    localparam logic [7:0] CHAN_MAX = 8'hFF;

endpackage

`default_nettype wire

### rtl/hslrgb_mix.sv
`default_nettype none

module hslrgb_mix #(
    parameter int FRAC_BITS = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire hslrgb_pkg::t_hsl_in i_data,
    output logic                     o_valid,
    input  wire                      i_ready,
    output logic [2*FRAC_BITS:0]     o_v2,
    output logic [2*FRAC_BITS:0]     o_d,
    output hslrgb_pkg::t_sextant     o_sext,
    output logic [FRAC_BITS-1:0]     o_fract
);
    import hslrgb_pkg::*;

    localparam int SW = FRAC_BITS + 1;
    localparam int IW = (FRAC_BITS + 1 > 17) ? FRAC_BITS + 1 : 17;
    localparam int PW = 2 * FRAC_BITS + 2;
    localparam int VW = 2 * FRAC_BITS + 1;
    localparam int HW = FRAC_BITS + 3;
    localparam logic [IW-1:0] ONE_X  = IW'(1) << FRAC_BITS;
    localparam logic [SW-1:0] HALF_S = SW'(1) << (FRAC_BITS - 1);

    logic r_vld1, r_vld2, r_vld3;
    logic rdy1, rdy2, rdy3;

    logic [IW-1:0]        sat_x, lit_x, hue_x;
    logic [SW-1:0]        n_s, n_l;
    logic [HW-1:0]        h6;
    logic [FRAC_BITS-1:0] hue_f;

    logic [SW-1:0]        r1_s, r1_l;
    t_sextant             r1_sext;
    logic [FRAC_BITS-1:0] r1_fract;

    logic [PW-1:0]        n_p;
    logic [PW-1:0]        r2_p;
    logic [SW-1:0]        r2_s, r2_l;
    t_sextant             r2_sext;
    logic [FRAC_BITS-1:0] r2_fract;

    logic [PW-1:0]        lone, sone, v2w, dw;
    logic                 low;
    logic [VW-1:0]        r3_v2, r3_d;
    t_sextant             r3_sext;
    logic [FRAC_BITS-1:0] r3_fract;

    assign rdy3    = i_ready | ~r_vld3;
    assign rdy2    = rdy3 | ~r_vld2;
    assign rdy1    = rdy2 | ~r_vld1;
    assign o_ready = rdy1;

    // stage 1: clamp and hue split
    assign sat_x = IW'(i_data.saturation);
    assign lit_x = IW'(i_data.lightness);
    assign hue_x = IW'(i_data.hue);
    assign n_s   = (sat_x > ONE_X) ? ONE_X[SW-1:0] : sat_x[SW-1:0];
    assign n_l   = (lit_x > ONE_X) ? ONE_X[SW-1:0] : lit_x[SW-1:0];
    assign hue_f = hue_x[FRAC_BITS-1:0];
    assign h6    = (HW'(hue_f) << 2) + (HW'(hue_f) << 1);

    // stage 2: lightness times saturation
    assign n_p = PW'(r1_l) * PW'(r1_s);

    // stage 3: peak and spread
    assign lone = PW'(r2_l) << FRAC_BITS;
    assign sone = PW'(r2_s) << FRAC_BITS;
    assign low  = (r2_l <= HALF_S);
    assign v2w  = low ? (lone + r2_p) : (lone + sone - r2_p);
    assign dw   = low ? (r2_p << 1) : ((sone - r2_p) << 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (rdy1) r_vld1 <= i_valid;
            if (rdy2) r_vld2 <= r_vld1;
            if (rdy3) r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_s     <= n_s;
            r1_l     <= n_l;
            r1_sext  <= t_sextant'(h6[HW-1:FRAC_BITS]);
            r1_fract <= h6[FRAC_BITS-1:0];
        end
        if (rdy2) begin
            r2_p     <= n_p;
            r2_s     <= r1_s;
            r2_l     <= r1_l;
            r2_sext  <= r1_sext;
            r2_fract <= r1_fract;
        end
        if (rdy3) begin
            r3_v2    <= v2w[VW-1:0];
            r3_d     <= dw[VW-1:0];
            r3_sext  <= r2_sext;
            r3_fract <= r2_fract;
        end
    end

    assign o_valid = r_vld3;
    assign o_v2    = r3_v2;
    assign o_d     = r3_d;
    assign o_sext  = r3_sext;
    assign o_fract = r3_fract;

    a_spread_below_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld3 |-> (r3_d <= r3_v2))
        else $error("spread exceeds peak value");

endmodule

`default_nettype wire

### rtl/hslrgb_sel.sv
`default_nettype none

module hslrgb_sel #(
    parameter int FRAC_BITS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire [2*FRAC_BITS:0]          i_v2,
    input  wire [2*FRAC_BITS:0]          i_d,
    input  wire hslrgb_pkg::t_sextant    i_sext,
    input  wire [FRAC_BITS-1:0]          i_fract,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [2:0][2*FRAC_BITS:0]    o_chan
);
    import hslrgb_pkg::*;

    localparam int VW = 2 * FRAC_BITS + 1;
    localparam logic [VW-1:0] ONE_SQ = VW'(1) << (2 * FRAC_BITS);

    logic rdy4, rdy5;
    logic r_vld4, r_vld5;

    logic [VW-1:0]          n_pa;
    logic [2*FRAC_BITS-1:0] n_pb;
    logic [VW-1:0]          r4_pa;
    logic [FRAC_BITS-1:0]   r4_pb;
    logic [VW-1:0]          r4_v2, r4_m2;
    t_sextant               r4_sext;

    logic [VW-1:0]          vsf, mid1, mid2;
    logic [2:0][VW-1:0]     n_chan;
    logic [2:0][VW-1:0]     r5_chan;

    assign rdy5    = i_ready | ~r_vld5;
    assign rdy4    = rdy5 | ~r_vld4;
    assign o_ready = rdy4;

    // stage 4: spread times hue fraction, split in two halves
    assign n_pa = VW'(i_d[VW-1:FRAC_BITS]) * VW'(i_fract);
    assign n_pb = (2*FRAC_BITS)'(i_d[FRAC_BITS-1:0]) * (2*FRAC_BITS)'(i_fract);

    // stage 5: ramps and channel order
    assign vsf  = r4_pa + VW'(r4_pb);
    assign mid1 = r4_m2 + vsf;
    assign mid2 = r4_v2 - vsf;

    always_comb begin
        unique case (r4_sext)
            SEXT_RY: n_chan = {r4_m2, mid1,  r4_v2};
            SEXT_YG: n_chan = {r4_m2, r4_v2, mid2};
            SEXT_GC: n_chan = {mid1,  r4_v2, r4_m2};
            SEXT_CB: n_chan = {r4_v2, mid2,  r4_m2};
            SEXT_BM: n_chan = {r4_v2, r4_m2, mid1};
            default: n_chan = {mid2,  r4_m2, r4_v2};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else begin
            if (rdy4) r_vld4 <= i_valid;
            if (rdy5) r_vld5 <= r_vld4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_pa   <= n_pa;
            r4_pb   <= n_pb[2*FRAC_BITS-1:FRAC_BITS];
            r4_v2   <= i_v2;
            r4_m2   <= i_v2 - i_d;
            r4_sext <= i_sext;
        end
        if (rdy5) begin
            r5_chan <= n_chan;
        end
    end

    assign o_valid = r_vld5;
    assign o_chan  = r5_chan;

    a_chan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld5 |-> (r5_chan[0] <= ONE_SQ && r5_chan[1] <= ONE_SQ && r5_chan[2] <= ONE_SQ))
        else $error("channel above full scale");

endmodule

`default_nettype wire

### rtl/hslrgb_out.sv
`default_nettype none

module hslrgb_out #(
    parameter int FRAC_BITS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire [2:0][2*FRAC_BITS:0]     i_chan,
    output logic                         o_valid,
    input  wire                          i_ready,
    output hslrgb_pkg::t_rgb_out         o_data
);
    import hslrgb_pkg::*;

    localparam int VW = 2 * FRAC_BITS + 1;
    localparam int SCW = VW + 8;

    logic              rdy6;
    logic              r_vld6;
    logic [2:0][SCW-1:0] scaled;
    logic [2:0][7:0]   byte_c;
    t_rgb_out          n_data, r_data;

    assign rdy6    = i_ready | ~r_vld6;
    assign o_ready = rdy6;

    // times 255, drop the fraction, saturate
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            scaled[k] = (SCW'(i_chan[k]) << 8) - SCW'(i_chan[k]);
            byte_c[k] = (scaled[k][SCW-1:2*FRAC_BITS] > 9'(CHAN_MAX))
                      ? CHAN_MAX : scaled[k][2*FRAC_BITS+7:2*FRAC_BITS];
        end
        n_data.red         = byte_c[0];
        n_data.green       = byte_c[1];
        n_data.blue        = byte_c[2];
        n_data.packed_argb = {ALPHA, byte_c[0], byte_c[1], byte_c[2]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld6 <= 1'b0;
        end else if (rdy6) begin
            r_vld6 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy6) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_vld6;
    assign o_data  = r_data;

endmodule

`default_nettype wire

### rtl/hsl_to_rgb_converter_top.sv
// channel   direction  handshake                      payload
// in        sink       i_in_valid / o_in_ready        i_in_data   (hue, saturation, lightness)
// out       source     o_out_valid / i_out_ready      o_out_data  (red, green, blue, packed_argb)
//
// one transaction per clock sustained while the output is not stalled
// six register stages: clamp, l*s multiply, v/d add, d*fract multiply, select, scale
// reset clears only the stage valid bits
// ready ripples back stage by stage, so empty stages fill while the output stalls
// in_ready drops only when all six stages hold a transaction
`default_nettype none

module hsl_to_rgb_converter_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_ready,
    input  wire hslrgb_pkg::t_hsl_in  i_in_data,
    output logic                      o_out_valid,
    input  wire                       i_out_ready,
    output hslrgb_pkg::t_rgb_out      o_out_data
);
    import hslrgb_pkg::*;

    localparam int VW = 2 * FRAC_BITS + 1;

    logic                 mix_valid, mix_ready;
    logic [VW-1:0]        mix_v2, mix_d;
    t_sextant             mix_sext;
    logic [FRAC_BITS-1:0] mix_fract;

    logic                 sel_valid, sel_ready;
    logic [2:0][VW-1:0]   sel_chan;

    hslrgb_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (mix_valid),
        .i_ready (mix_ready),
        .o_v2    (mix_v2),
        .o_d     (mix_d),
        .o_sext  (mix_sext),
        .o_fract (mix_fract)
    );

    hslrgb_sel #(.FRAC_BITS(FRAC_BITS)) u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mix_valid),
        .o_ready (mix_ready),
        .i_v2    (mix_v2),
        .i_d     (mix_d),
        .i_sext  (mix_sext),
        .i_fract (mix_fract),
        .o_valid (sel_valid),
        .i_ready (sel_ready),
        .o_chan  (sel_chan)
    );

    hslrgb_out #(.FRAC_BITS(FRAC_BITS)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sel_valid),
        .o_ready (sel_ready),
        .i_chan  (sel_chan),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready && sel_valid && mix_valid))
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

### test/hsl_rgb_checker.sv
`timescale 1ns / 100ps

module hsl_rgb_checker #(
    parameter int FRAC_BITS = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  wire                   i_in_ready,
    input  hslrgb_pkg::t_hsl_in   i_in_data,
    input  wire                   i_out_valid,
    input  wire                   i_out_ready,
    input  hslrgb_pkg::t_rgb_out  i_out_data,
    output int                    o_err_count,
    output int                    o_pending
);
    import hslrgb_pkg::*;

    localparam logic [63:0] ONE       = 64'd1 << FRAC_BITS;
    localparam logic [63:0] HALF      = ONE >> 1;
    localparam logic [63:0] FRAC_MASK = ONE - 64'd1;

    t_rgb_out rgb_expected[$];
    t_rgb_out rgb_want;
    int       err_count = 0;

    assign o_err_count = err_count;

    function automatic logic [7:0] scale_channel(input logic [63:0] c);
        logic [63:0] x;
        x = (c * 64'd255) >> (2 * FRAC_BITS);
        return (x > 64'd255) ? CHAN_MAX : x[7:0];
    endfunction

    function automatic t_rgb_out hsl_to_argb(input t_hsl_in px);
        logic [63:0] h, s, l, v2, m2, d, h6, fract, vsf, mid1, mid2, r, g, b;
        t_sextant    sext;
        t_rgb_out    res;
        h = 64'(px.hue) & FRAC_MASK;
        s = 64'(px.saturation);
        l = 64'(px.lightness);
        if (s > ONE) s = ONE;
        if (l > ONE) l = ONE;
        // peak and spread, both in units of 1/ONE^2
        if (l <= HALF) begin
            v2 = l * (ONE + s);
            d  = 64'd2 * l * s;
        end else begin
            v2 = (l + s) * ONE - l * s;
            d  = 64'd2 * s * (ONE - l);
        end
        r = l * ONE;
        g = r;
        b = r;
        if (v2 != 64'd0) begin
            m2    = v2 - d;
            h6    = h * 64'd6;
            sext  = t_sextant'(3'(h6 >> FRAC_BITS));
            fract = h6 & FRAC_MASK;
            vsf   = (d >> FRAC_BITS) * fract + (((d & FRAC_MASK) * fract) >> FRAC_BITS);
            mid1  = m2 + vsf;
            mid2  = v2 - vsf;
            case (sext)
                SEXT_RY: begin
                    r = v2;   g = mid1; b = m2;
                end
                SEXT_YG: begin
                    r = mid2; g = v2;   b = m2;
                end
                SEXT_GC: begin
                    r = m2;   g = v2;   b = mid1;
                end
                SEXT_CB: begin
                    r = m2;   g = mid2; b = v2;
                end
                SEXT_BM: begin
                    r = mid1; g = m2;   b = v2;
                end
                default: begin
                    r = v2;   g = m2;   b = mid2;
                end
            endcase
        end
        res.red         = scale_channel(r);
        res.green       = scale_channel(g);
        res.blue        = scale_channel(b);
        res.packed_argb = {ALPHA, res.red, res.green, res.blue};
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (rgb_expected.size() == 0) begin
                    $display("%0t: unexpected rgb transaction, expected none, actual %h",
                             $time, i_out_data);
                    err_count++;
                end else begin
                    rgb_want = rgb_expected.pop_front();
                    check_field("red", 32'(rgb_want.red), 32'(i_out_data.red));
                    check_field("green", 32'(rgb_want.green), 32'(i_out_data.green));
                    check_field("blue", 32'(rgb_want.blue), 32'(i_out_data.blue));
                    check_field("packed_argb", rgb_want.packed_argb, i_out_data.packed_argb);
                end
            end
            if (i_in_valid && i_in_ready) begin
                rgb_expected.push_back(hsl_to_argb(i_in_data));
            end
            o_pending <= rgb_expected.size();
        end
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import hslrgb_pkg::*;

    localparam int FRAC_BITS      = 16;
    localparam int RANDOM_ITEMS   = 1030;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    t_hsl_in  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_rgb_out out_data;
    int       err_count;
    int       pending;

    int       hold_reqs   = 0;
    bit       hold_active = 1'b0;
    int       burst_left  = 0;
    int       idle_cycles = 0;

    hsl_to_rgb_converter_top #(
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    hsl_rgb_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic t_hsl_in hsl(input int h, input int s, input int l);
        t_hsl_in px;
        px.hue        = 16'(h);
        px.saturation = 17'(s);
        px.lightness  = 17'(l);
        return px;
    endfunction

    function automatic int rand_level();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return 65536;
            2:       return int'(17'($urandom));
            3:       return 32767 + $urandom_range(0, 2);
            4:       return $urandom_range(0, 3);
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    function automatic int rand_hue();
        int h;
        if ($urandom_range(0, 3) == 0) begin
            // near a sextant boundary
            h = ($urandom_range(0, 6) * 65536) / 6 + $urandom_range(0, 6) - 3;
            if (h < 0) h = 0;
            if (h > 65535) h = 65535;
            return h;
        end
        return int'(16'($urandom));
    endfunction

    task automatic send_hsl(input t_hsl_in px);
        int gap;
        in_valid <= 1'b1;
        in_data  <= px;
        do @(posedge clk); while (!in_ready);
        if (!hold_active) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end else begin
                burst_left--;
            end
        end
    endtask

    // receiver stall pattern
    initial begin
        int mode;
        int mode_left;
        int holds_done;
        mode_left = 0;
        mode = 0;
        holds_done = 0;
        forever begin
            @(posedge clk);
            if (hold_reqs != holds_done) begin
                holds_done++;
                hold_active = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 7) != 0);
                    default: out_ready <= (mode_left % 3 == 0);
                endcase
            end
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // gray at zero lightness, white, zero saturation
        send_hsl(hsl(0, 0, 0));
        send_hsl(hsl(65535, 65536, 0));
        send_hsl(hsl(0, 0, 65536));
        send_hsl(hsl(12345, 0, 40000));
        // pure hues covering every sextant, the last sextant twice
        send_hsl(hsl(0, 65536, 32768));
        send_hsl(hsl(10923, 65536, 32768));
        send_hsl(hsl(21846, 65536, 32768));
        send_hsl(hsl(32768, 65536, 32768));
        send_hsl(hsl(43691, 65536, 32768));
        send_hsl(hsl(54614, 65536, 32768));
        send_hsl(hsl(65535, 65536, 32768));
        // sextant edges and lightness around one half
        send_hsl(hsl(10922, 65536, 32768));
        send_hsl(hsl(21845, 65536, 32768));
        send_hsl(hsl(20000, 65536, 32769));
        // saturation or lightness above one, then small and near-one values
        send_hsl(hsl(20000, 131071, 32768));
        send_hsl(hsl(40000, 65536, 131071));
        send_hsl(hsl(50000, 131071, 131071));
        send_hsl(hsl(5000, 65537, 1));
        send_hsl(hsl(65535, 1, 1));
        send_hsl(hsl(30000, 65535, 65535));
        send_hsl(hsl('hAAAA, 'h0AAAA, 'h15555));
        send_hsl(hsl('h5555, 'h15555, 'h0AAAA));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 200 || i == 700) begin
                hold_reqs++;
            end
            send_hsl(hsl(rand_hue(), rand_level(), rand_level()));
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### hsl_to_rgb_converter_top.f
rtl/hslrgb_pkg.sv
rtl/hslrgb_mix.sv
rtl/hslrgb_sel.sv
rtl/hslrgb_out.sv
rtl/hsl_to_rgb_converter_top.sv
test/hsl_rgb_checker.sv
test/tb_top.sv
